FILE: hdl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, codes and types of the slotted page directory.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int MAX_SLOTS    = 256;
	localparam int HEADER_BYTES = 16;
	localparam int SLOT_BYTES   = 8;

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int OFF_W  = 13;
	localparam int NEED_W = $clog2(HEADER_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES + 2 ** OFF_W);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_SLOT = 2'd2
	} status_t;

	typedef struct packed {
		logic             valid;
		logic [OFF_W-1:0] offset;
		logic [OFF_W-1:0] length;
		logic             blob;
	} slot_entry_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [OFF_W-1:0]  offset;
		logic [OFF_W-1:0]  length;
		logic              blob;
		logic [OFF_W-1:0]  move_source;
		logic [OFF_W-1:0]  move_size;
	} rsp_t;

endpackage

FILE: hdl/spd_ram.sv
// ----------------------------------------------------------------------------
// spd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 27
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/spd_ctrl.sv
// ----------------------------------------------------------------------------
// spd_ctrl
// Request sequencer: slot checks, free-slot search, offset sweep on remove,
// space accounting and the response register.
// ----------------------------------------------------------------------------
module spd_ctrl import spd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        req_type,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [OFF_W-1:0]  record_length,
	input  logic              is_blob,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	output logic              mem_we,
	output logic [SLOT_W-1:0] mem_waddr,
	output slot_entry_t       mem_wdata,
	output logic [SLOT_W-1:0] mem_raddr,
	input  slot_entry_t       mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_SWEEP,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  live_q;
	logic [CNT_W-1:0]  freed_q;
	logic [OFF_W-1:0]  free_end_q;
	logic [1:0]        req_q;
	logic [SLOT_W-1:0] idx_q;
	logic [OFF_W-1:0]  len_q;
	logic              blob_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [OFF_W-1:0]  off_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              rsp_valid_q;

	logic [CNT_W-1:0]  count;
	logic [CNT_W-1:0]  ins_slots;
	logic [OFF_W-1:0]  ins_len;
	logic              ins_blob;
	logic [NEED_W-1:0] ins_need;
	logic              ins_fit;
	logic              accept;
	logic              idx_bad;
	logic              ptr_last;
	logic              rsp_load;
	slot_entry_t       new_entry;

	function automatic rsp_t bad_rsp(input logic [SLOT_W-1:0] idx);
		rsp_t r;
		r = '0;
		r.status = ST_BAD_SLOT;
		r.slot = idx;
		return r;
	endfunction

	function automatic rsp_t full_rsp();
		rsp_t r;
		r = '0;
		r.status = ST_NO_SPACE;
		return r;
	endfunction

	function automatic rsp_t ok_rsp(input logic [SLOT_W-1:0] idx,
	                                input logic [OFF_W-1:0]  off,
	                                input logic [OFF_W-1:0]  len,
	                                input logic              blob,
	                                input logic [OFF_W-1:0]  msrc,
	                                input logic [OFF_W-1:0]  msize);
		rsp_t r;
		r = '0;
		r.status      = ST_OK;
		r.slot        = idx;
		r.offset      = off;
		r.length      = len;
		r.blob        = blob;
		r.move_source = msrc;
		r.move_size   = msize;
		return r;
	endfunction

	assign count     = live_q + freed_q;
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign idx_bad   = (CNT_W'(slot_index) >= count);
	assign ptr_last  = ((CNT_W'(ptr_q) + CNT_W'(1)) == count);
	assign rsp_load  = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	assign ins_slots = (state_q == S_IDLE) ? (count + CNT_W'(1)) : count;
	assign ins_len   = (state_q == S_IDLE) ? record_length : len_q;
	assign ins_blob  = (state_q == S_IDLE) ? is_blob : blob_q;
	assign ins_need  = NEED_W'(HEADER_BYTES) + NEED_W'(ins_slots) * NEED_W'(SLOT_BYTES)
		+ NEED_W'(ins_len);
	assign ins_fit   = (ins_need <= NEED_W'(free_end_q));

	always_comb begin
		new_entry.valid  = 1'b1;
		new_entry.offset = free_end_q - ins_len;
		new_entry.length = ins_len;
		new_entry.blob   = ins_blob;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = mem_rdata;
		mem_raddr = ptr_q + SLOT_W'(1);
		unique case (state_q)
			S_IDLE: begin
				mem_raddr = (req_type == REQ_INSERT) ? '0 : slot_index;
				mem_waddr = count[SLOT_W-1:0];
				mem_wdata = new_entry;
				mem_we    = accept && (req_type == REQ_INSERT) && (freed_q == '0)
					&& (count < CNT_W'(MAX_SLOTS)) && ins_fit;
			end
			S_CHECK: begin
				mem_raddr = '0;
			end
			S_SEARCH: begin
				mem_wdata = new_entry;
				mem_we    = !mem_rdata.valid && ins_fit;
			end
			S_SWEEP: begin
				if (ptr_q == idx_q) begin
					mem_wdata.valid = 1'b0;
					mem_we = 1'b1;
				end else if (mem_rdata.valid && (mem_rdata.offset >= free_end_q)
						&& (mem_rdata.offset < off_q)) begin
					mem_wdata.offset = mem_rdata.offset + len_q;
					mem_we = 1'b1;
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= '0;
			freed_q     <= '0;
			free_end_q  <= OFF_W'(PAGE_BYTES);
			req_q       <= REQ_INSERT;
			idx_q       <= '0;
			len_q       <= '0;
			blob_q      <= 1'b0;
			ptr_q       <= '0;
			off_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q  <= req_type;
						idx_q  <= slot_index;
						len_q  <= record_length;
						blob_q <= is_blob;
						ptr_q  <= '0;
						unique case (req_type) inside
							REQ_INSERT: begin
								if (freed_q != '0) begin
									state_q <= S_SEARCH;
								end else if ((count >= CNT_W'(MAX_SLOTS)) || !ins_fit) begin
									res_q   <= full_rsp();
									state_q <= S_FIN;
								end else begin
									res_q      <= ok_rsp(count[SLOT_W-1:0], new_entry.offset,
										record_length, is_blob, '0, '0);
									free_end_q <= new_entry.offset;
									live_q     <= live_q + CNT_W'(1);
									state_q    <= S_FIN;
								end
							end
							REQ_REMOVE, REQ_LOOKUP: begin
								if (idx_bad) begin
									res_q   <= bad_rsp(slot_index);
									state_q <= S_FIN;
								end else begin
									state_q <= S_CHECK;
								end
							end
							default: begin
								res_q   <= bad_rsp(slot_index);
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_CHECK: begin
					if (!mem_rdata.valid) begin
						res_q   <= bad_rsp(idx_q);
						state_q <= S_FIN;
					end else if (req_q == REQ_LOOKUP) begin
						res_q   <= ok_rsp(idx_q, mem_rdata.offset, mem_rdata.length,
							mem_rdata.blob, '0, '0);
						state_q <= S_FIN;
					end else begin
						res_q   <= ok_rsp(idx_q, mem_rdata.offset, mem_rdata.length,
							mem_rdata.blob, free_end_q, mem_rdata.offset - free_end_q);
						off_q   <= mem_rdata.offset;
						len_q   <= mem_rdata.length;
						ptr_q   <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SEARCH: begin
					if (!mem_rdata.valid) begin
						if (ins_fit) begin
							res_q      <= ok_rsp(ptr_q, new_entry.offset, len_q, blob_q,
								'0, '0);
							free_end_q <= new_entry.offset;
							live_q     <= live_q + CNT_W'(1);
							freed_q    <= freed_q - CNT_W'(1);
						end else begin
							res_q <= full_rsp();
						end
						state_q <= S_FIN;
					end else begin
						ptr_q <= ptr_q + SLOT_W'(1);
					end
				end
				S_SWEEP: begin
					if (ptr_last) begin
						free_end_q <= free_end_q + len_q;
						live_q     <= live_q - CNT_W'(1);
						freed_q    <= freed_q + CNT_W'(1);
						state_q    <= S_FIN;
					end else begin
						ptr_q <= ptr_q + SLOT_W'(1);
					end
				end
				S_FIN: begin
					if (rsp_load) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = out_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(MAX_SLOTS))
		else $error("slot count beyond table size");

	a_free_end_max: assert property (@(posedge clk) disable iff (!arst_n)
		free_end_q <= OFF_W'(PAGE_BYTES))
		else $error("free end beyond page end");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request taken without going busy");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (CNT_W'(ptr_q) < count))
		else $error("sweep pointer past slot count");

	a_search_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (freed_q != '0))
		else $error("free-slot search with no freed slot");

endmodule

FILE: hdl/slotted_page_directory.sv
// ----------------------------------------------------------------------------
// slotted_page_directory
// Slot directory of one database page: insert, remove and look up of slots.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall   req_type slot_index record_length is_blob
//  response  out        rsp_valid / rsp_stall   status slot_out record_offset length_out
//                                               blob_out move_source move_size
//
//  Unknown requests, indexes past the slot count and inserts without reuse go
//  straight to the response; lookup and remove first read the slot, and a freed
//  slot ends there; a reusing insert searches up to the first freed slot; remove
//  sweeps every slot (read-modify-write of the slot RAM); new requests wait for idle.
//  Reset empties the directory; the slot RAM itself is not cleared.
//  A stalled response holds; the next request is taken but held at its final step.
// ----------------------------------------------------------------------------
module slotted_page_directory import spd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        req_type,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [OFF_W-1:0]  record_length,
	input  logic              is_blob,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot_out,
	output logic [OFF_W-1:0]  record_offset,
	output logic [OFF_W-1:0]  length_out,
	output logic              blob_out,
	output logic [OFF_W-1:0]  move_source,
	output logic [OFF_W-1:0]  move_size
);

	rsp_t              rsp;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	slot_entry_t       mem_wdata;
	logic [SLOT_W-1:0] mem_raddr;
	slot_entry_t       mem_rdata;

	spd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.slot_index    (slot_index),
		.record_length (record_length),
		.is_blob       (is_blob),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	spd_ram #(
		.DEPTH (MAX_SLOTS),
		.WIDTH ($bits(slot_entry_t))
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign status        = rsp.status;
	assign slot_out      = rsp.slot;
	assign record_offset = rsp.offset;
	assign length_out    = rsp.length;
	assign blob_out      = rsp.blob;
	assign move_source   = rsp.move_source;
	assign move_size     = rsp.move_size;

endmodule

FILE: test/slotted_page_directory_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_page_directory_test
// Drives insert, remove, lookup and unknown requests into the slot directory
// and checks every response field against a cycle-free model of the page
// kept in the bench. Directed corner cases come first, then random phases
// with varied back-pressure: mixed traffic, a drain, a long response hold and
// a fill up to the slot limit.
// ----------------------------------------------------------------------------
module slotted_page_directory_test;
	import spd_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 600;
	localparam int TAIL_CYCLES    = 300;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SLOT_W-1:0] slot;
		logic [OFF_W-1:0]  length;
		logic              blob;
	} page_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        req_type = REQ_INSERT;
	logic [SLOT_W-1:0] slot_index = '0;
	logic [OFF_W-1:0]  record_length = '0;
	logic              is_blob = 1'b0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot_out;
	logic [OFF_W-1:0]  record_offset;
	logic [OFF_W-1:0]  length_out;
	logic              blob_out;
	logic [OFF_W-1:0]  move_source;
	logic [OFF_W-1:0]  move_size;

	slotted_page_directory dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.slot_index(slot_index),
		.record_length(record_length),
		.is_blob(is_blob),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.slot_out(slot_out),
		.record_offset(record_offset),
		.length_out(length_out),
		.blob_out(blob_out),
		.move_source(move_source),
		.move_size(move_size)
	);

	// page model
	bit dir_used   [MAX_SLOTS];
	int dir_offset [MAX_SLOTS];
	int dir_length [MAX_SLOTS];
	bit dir_blob   [MAX_SLOTS];
	int live_slots  = 0;
	int freed_slots = 0;
	int page_low    = PAGE_BYTES;

	page_req_t queued_requests[$];
	rsp_t      pending_responses[$];

	bit failed       = 1'b0;
	bit req_accepted = 1'b0;
	int quiet_cycles = 0;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int hold_orders  = 0;
	int hold_served  = 0;
	int hold_left    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t predict_directory_response(page_req_t rq);
		rsp_t r;
		int   used;
		int   target;
		int   k;
		int   rec_off;
		int   len;
		int   slots_after;
		bit   reuse;
		r = '0;
		r.status = ST_BAD_SLOT;
		r.slot = rq.slot;
		used = live_slots + freed_slots;
		case (rq.kind)
			REQ_INSERT: begin
				r.status = ST_NO_SPACE;
				r.slot = '0;
				target = used;
				reuse = 1'b0;
				if (freed_slots != 0) begin
					for (k = 0; k < used; k++) begin
						if (!dir_used[k]) begin
							target = k;
							reuse = 1'b1;
							break;
						end
					end
				end
				slots_after = reuse ? used : used + 1;
				len = int'(rq.length);
				if ((reuse || used < MAX_SLOTS) &&
				    page_low >= HEADER_BYTES + slots_after * SLOT_BYTES + len) begin
					if (reuse)
						freed_slots--;
					live_slots++;
					page_low -= len;
					dir_used[target] = 1'b1;
					dir_offset[target] = page_low;
					dir_length[target] = len;
					dir_blob[target] = rq.blob;
					r.status = ST_OK;
					r.slot = SLOT_W'(target);
					r.offset = OFF_W'(page_low);
					r.length = OFF_W'(len);
					r.blob = rq.blob;
				end
			end
			REQ_REMOVE: begin
				if (rq.slot < used && dir_used[rq.slot]) begin
					rec_off = dir_offset[rq.slot];
					len = dir_length[rq.slot];
					// shift up every record packed between the free end and this one
					for (k = 0; k < used; k++) begin
						if (dir_used[k] && dir_offset[k] >= page_low && dir_offset[k] < rec_off)
							dir_offset[k] += len;
					end
					r.status = ST_OK;
					r.offset = OFF_W'(rec_off);
					r.length = OFF_W'(len);
					r.blob = dir_blob[rq.slot];
					r.move_source = OFF_W'(page_low);
					r.move_size = OFF_W'(rec_off - page_low);
					page_low += len;
					dir_used[rq.slot] = 1'b0;
					live_slots--;
					freed_slots++;
				end
			end
			REQ_LOOKUP: begin
				if (rq.slot < used && dir_used[rq.slot]) begin
					r.status = ST_OK;
					r.offset = OFF_W'(dir_offset[rq.slot]);
					r.length = OFF_W'(dir_length[rq.slot]);
					r.blob = dir_blob[rq.slot];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		int used;
		int start;
		int roll;
		int k;
		logic [SLOT_W-1:0] s;
		used = live_slots + freed_slots;
		s = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
		roll = $urandom_range(0, 9);
		if (used > 0 && roll < 8) begin
			start = $urandom_range(0, used - 1);
			s = SLOT_W'(start);
			if (roll < 6) begin
				for (k = 0; k < used; k++) begin
					if (dir_used[(start + k) % used]) begin
						s = SLOT_W'((start + k) % used);
						break;
					end
				end
			end
		end
		return s;
	endfunction

	function automatic page_req_t make_request(int ins_pct, int len_cap, bit odd_lengths);
		page_req_t rq;
		int roll;
		int pick;
		int used;
		int room;
		rq.kind = REQ_UNKNOWN;
		rq.slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
		rq.length = OFF_W'($urandom_range(0, PAGE_BYTES));
		rq.blob = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < ins_pct) begin
			rq.kind = REQ_INSERT;
			pick = $urandom_range(0, 19);
			used = live_slots + freed_slots;
			if (odd_lengths && pick == 0) begin
				rq.length = OFF_W'($urandom_range(0, PAGE_BYTES));
			end else if (odd_lengths && pick == 1) begin
				rq.length = OFF_W'(PAGE_BYTES);
			end else if (odd_lengths && pick == 2) begin
				// exact fit, or one byte over
				room = page_low - HEADER_BYTES
				       - (freed_slots != 0 ? used : used + 1) * SLOT_BYTES
				       + int'($urandom_range(0, 1));
				if (room < 0)
					room = 0;
				if (room > PAGE_BYTES)
					room = PAGE_BYTES;
				rq.length = OFF_W'(room);
			end else begin
				rq.length = OFF_W'($urandom_range(0, len_cap));
			end
		end else if (roll < 97) begin
			rq.kind = ($urandom_range(0, 99) < 55) ? REQ_REMOVE : REQ_LOOKUP;
			rq.slot = pick_slot();
		end
		return rq;
	endfunction

	task automatic wait_for_room();
		while (queued_requests.size() >= 2)
			@(posedge clk);
	endtask

	task automatic feed(input logic [1:0] kind, input int slot, input int len, input bit blob);
		page_req_t rq;
		rq.kind = kind;
		rq.slot = SLOT_W'(slot);
		rq.length = OFF_W'(len);
		rq.blob = blob;
		wait_for_room();
		queued_requests.push_back(rq);
	endtask

	task automatic run_random(input int count, input int ins_pct, input int len_cap,
	                          input bit odd_lengths);
		for (int n = 0; n < count; n++) begin
			wait_for_room();
			queued_requests.push_back(make_request(ins_pct, len_cap, odd_lengths));
		end
	endtask

	task automatic settle();
		while (queued_requests.size() != 0 || req_valid || pending_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
	                           input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			failed = 1'b1;
		end
	endtask

	always @(negedge clk) begin : driver
		page_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_accepted) begin
			if (queued_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nxt = queued_requests.pop_front();
				req_type <= nxt.kind;
				slot_index <= nxt.slot;
				record_length <= nxt.length;
				is_blob <= nxt.blob;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : response_stall
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (hold_served != hold_orders) begin
			hold_served = hold_orders;
			hold_left = LONG_HOLD - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		page_req_t seen;
		rsp_t      want;
		bit        rsp_taken;
		if (arst_n) begin
			req_accepted = req_valid && !req_stall;
			rsp_taken = rsp_valid && !rsp_stall;
			if (req_accepted) begin
				seen.kind = req_type;
				seen.slot = slot_index;
				seen.length = record_length;
				seen.blob = is_blob;
				pending_responses.push_back(predict_directory_response(seen));
			end
			if (rsp_taken) begin
				if (pending_responses.size() == 0) begin
					$display("%0t: response with none expected: status %0d slot %0d",
					         $time, status, slot_out);
					failed = 1'b1;
				end else begin
					want = pending_responses.pop_front();
					check_field("status", 16'(want.status), 16'(status));
					check_field("slot_out", 16'(want.slot), 16'(slot_out));
					check_field("record_offset", 16'(want.offset), 16'(record_offset));
					check_field("length_out", 16'(want.length), 16'(length_out));
					check_field("blob_out", 16'(want.blob), 16'(blob_out));
					check_field("move_source", 16'(want.move_source), 16'(move_source));
					check_field("move_size", 16'(want.move_size), 16'(move_size));
				end
			end
			if (req_accepted || rsp_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int room;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		feed(REQ_LOOKUP, 0, 0, 0);
		feed(REQ_REMOVE, 0, 0, 0);
		feed(REQ_UNKNOWN, 255, PAGE_BYTES, 1);
		feed(REQ_INSERT, 8'hAA, 0, 1);
		feed(REQ_INSERT, 0, PAGE_BYTES, 0);
		feed(REQ_INSERT, 255, 100, 0);
		feed(REQ_INSERT, 0, 200, 1);
		feed(REQ_INSERT, 8'h55, 13'h0555, 0);
		feed(REQ_LOOKUP, 1, 13'h1FFF & PAGE_BYTES, 1);
		feed(REQ_LOOKUP, 3, 0, 0);
		feed(REQ_REMOVE, 1, 0, 0);
		feed(REQ_LOOKUP, 2, 0, 0);
		feed(REQ_LOOKUP, 1, 0, 0);
		feed(REQ_REMOVE, 255, 0, 1);
		feed(REQ_LOOKUP, 4, 0, 0);
		feed(REQ_INSERT, 0, 50, 1);
		feed(REQ_LOOKUP, 1, 0, 0);
		settle();
		// fill the page to the last byte, then ask for one more slot
		room = page_low - HEADER_BYTES - (live_slots + freed_slots + 1) * SLOT_BYTES;
		feed(REQ_INSERT, 0, room, 1);
		feed(REQ_INSERT, 0, 0, 0);
		feed(REQ_REMOVE, 0, 0, 0);
		feed(REQ_INSERT, 0, 0, 1);
		feed(REQ_REMOVE, 2, 0, 0);
		feed(REQ_REMOVE, 3, 0, 0);
		feed(REQ_REMOVE, 4, 0, 0);

		idle_pct = 0;
		stall_pct = 0;
		run_random(225, 55, 40, 1);
		idle_pct = 46;
		run_random(225, 55, 40, 1);
		idle_pct = 0;
		stall_pct = 46;
		run_random(225, 50, 200, 1);
		idle_pct = 12;
		stall_pct = 12;
		run_random(225, 45, 24, 1);
		run_random(150, 15, 24, 1);

		// hold responses back while requests keep coming
		idle_pct = 0;
		stall_pct = 0;
		settle();
		hold_orders++;
		run_random(60, 50, 30, 1);

		stall_pct = 46;
		run_random(320, 90, 4, 0);
		idle_pct = 12;
		stall_pct = 12;
		run_random(100, 45, 24, 1);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed && pending_responses.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
